[rtl/core/heartbeat_consumer_monitor_unit_assert.svh]
// Assertion macros used by the heartbeat consumer monitor checker.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef HEARTBEAT_CONSUMER_MONITOR_UNIT_ASSERT_SVH
`define HEARTBEAT_CONSUMER_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define HBCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("heartbeat monitor check failed");

// Next-cycle implication, disabled while in reset.
`define HBCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("heartbeat monitor check failed");

`endif

[rtl/core/hbcm_pkg.sv]
// Types and constants of the heartbeat consumer monitor.
// No dependencies; used by the top level and its checker.
package hbcm_pkg;

    localparam int unsigned MAX_NODE_ID = 127;

    localparam int unsigned NODE_ID_W = 8;
    localparam int unsigned HB_MS_W   = 16;
    localparam int unsigned CAN_ID_W  = 11;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned STATE_W   = 8;
    localparam int unsigned NODE_W    = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 16;

    localparam logic [CAN_ID_W-1:0] HB_COB_BASE = 11'h700;

    typedef enum logic [1:0] {
        ACT_FRAME = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_FORCE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        EV_TIMEOUT  = 2'd0,
        EV_RESOLVED = 2'd1,
        EV_CHANGED  = 2'd2
    } t_event;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_MS   = 2'd1;

    typedef struct packed {
        t_event              kind;
        logic [STATE_W-1:0]  state;
        logic                last;
    } t_result;

endpackage

[rtl/core/heartbeat_consumer_monitor_unit.sv]
// Heartbeat consumer monitor: top level, input stage, state update and result buffer.
// Depends on hbcm_pkg.
//
// Watches the heartbeat of one remote node. Monitoring is on when node_id is 1 to 127 and
// heartbeat_ms is nonzero. Each input beat is a received frame, a millisecond tick or a
// forced node state (tuser). A frame with identifier 0x700 + node_id, a nonzero length and
// a clear toggle bit stores the state, clears a timeout error and restarts the countdown;
// it reports "timeout resolved" (if an error was pending) and then "state changed" (if the
// state differs). A tick decrements the running countdown and reports "timeout occurred"
// when it reaches zero. A forced state acts like a valid frame but reports nothing.
// Writing either configuration register stops the countdown and clears the state; write
// only while the block is idle. Throughput is one input beat per clock: an input register
// feeds the state update, which writes into a two-entry result buffer, so the first result
// is offered in the cycle after the item leaves the input register. An item that yields two
// events gives two result beats; the input side stalls only while the buffer lacks room.
module heartbeat_consumer_monitor_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [hbcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hbcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input beats
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [hbcm_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // can_id, frame_len, status_byte, pad
    input  logic [1:0]                          i_s_axis_tuser,  // action
    // result beats
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [hbcm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // node, node_state, pad
    output logic [1:0]                          o_m_axis_tuser,  // event_kind
    output logic                                o_m_axis_tlast
);

    localparam int unsigned LEN_LO = hbcm_pkg::CAN_ID_W;
    localparam int unsigned ST_LO  = hbcm_pkg::CAN_ID_W + hbcm_pkg::LEN_W;

    // configuration and monitor state
    logic [hbcm_pkg::NODE_ID_W-1:0] r_node_id, n_node_id;
    logic [hbcm_pkg::HB_MS_W-1:0]   r_hb_ms, n_hb_ms;
    logic [hbcm_pkg::STATE_W-1:0]   r_state, n_state;
    logic                           r_err, n_err;
    logic [hbcm_pkg::HB_MS_W-1:0]   r_count, n_count;
    logic                           r_run, n_run;

    // input register
    logic                           r_in_valid, n_in_valid;
    hbcm_pkg::t_action              r_in_action;
    logic [hbcm_pkg::CAN_ID_W-1:0]  r_in_can_id;
    logic [hbcm_pkg::LEN_W-1:0]     r_in_len;
    logic [hbcm_pkg::STATE_W-1:0]   r_in_st;

    // result buffer, entry 0 is the head
    hbcm_pkg::t_result              r_ob [2];
    hbcm_pkg::t_result              n_ob [2];
    logic [1:0]                     r_ob_cnt, n_ob_cnt;

    logic                           in_accept;
    logic                           pop;
    logic                           fire;
    logic                           mon_on;
    logic                           frame_ok;
    logic                           ev_res, ev_chg, ev_exp;
    logic [1:0]                     nres;
    logic [1:0]                     cnt_after_pop;
    logic [hbcm_pkg::HB_MS_W-1:0]   count_dec;
    hbcm_pkg::t_result              res0, res1;

    // -- handshakes ------------------------------------------------------------------------
    assign pop             = o_m_axis_tvalid && i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !r_in_valid || fire;

    assign o_m_axis_tvalid = (r_ob_cnt != 2'd0);
    assign o_m_axis_tuser  = r_ob[0].kind;
    assign o_m_axis_tlast  = r_ob[0].last;
    assign o_m_axis_tdata  = {1'b0, r_ob[0].state, r_node_id[hbcm_pkg::NODE_W-1:0]};

    // -- event decode for the item held in the input register ------------------------------
    assign mon_on = (r_node_id != '0)
                 && (r_node_id <= hbcm_pkg::NODE_ID_W'(hbcm_pkg::MAX_NODE_ID))
                 && (r_hb_ms != '0);

    assign frame_ok = mon_on
                   && (r_in_can_id == hbcm_pkg::HB_COB_BASE
                                      + hbcm_pkg::CAN_ID_W'(r_node_id))
                   && (r_in_len != '0)
                   && !r_in_st[hbcm_pkg::STATE_W-1];

    // a countdown found at zero expires on the same tick
    assign count_dec = (r_count != '0) ? r_count - hbcm_pkg::HB_MS_W'(1) : r_count;

    always_comb begin
        ev_res = 1'b0;
        ev_chg = 1'b0;
        ev_exp = 1'b0;
        unique case (r_in_action)
            hbcm_pkg::ACT_FRAME: begin
                ev_res = frame_ok && r_err;
                ev_chg = frame_ok && (r_in_st != r_state);
            end
            hbcm_pkg::ACT_TICK: begin
                ev_exp = r_run && (count_dec == '0);
            end
            default: ;
        endcase
    end

    assign nres = 2'(ev_res) + 2'(ev_chg) + 2'(ev_exp);

    // first and second result of the item; resolved precedes changed
    always_comb begin
        res0.kind  = ev_exp ? hbcm_pkg::EV_TIMEOUT
                   : (ev_res ? hbcm_pkg::EV_RESOLVED : hbcm_pkg::EV_CHANGED);
        res0.state = (!ev_exp && !ev_res) ? r_in_st : '0;
        res0.last  = (nres == 2'd1);
        res1.kind  = hbcm_pkg::EV_CHANGED;
        res1.state = r_in_st;
        res1.last  = 1'b1;
    end

    // take the item once the buffer has room for all of its results
    assign cnt_after_pop = r_ob_cnt - 2'(pop);
    assign fire = r_in_valid && ((3'(cnt_after_pop) + 3'(nres)) <= 3'd2);

    // -- next state ------------------------------------------------------------------------
    always_comb begin
        n_node_id = r_node_id;
        n_hb_ms   = r_hb_ms;
        n_state   = r_state;
        n_err     = r_err;
        n_count   = r_count;
        n_run     = r_run;
        if (i_cfg_we) begin
            // any register write clears the monitor; unknown indexes change nothing
            unique case (i_cfg_index)
                hbcm_pkg::CFG_NODE_ID: begin
                    n_node_id = i_cfg_data[hbcm_pkg::NODE_ID_W-1:0];
                    n_state   = '0;
                    n_err     = 1'b0;
                    n_count   = '0;
                    n_run     = 1'b0;
                end
                hbcm_pkg::CFG_HB_MS: begin
                    n_hb_ms = i_cfg_data;
                    n_state = '0;
                    n_err   = 1'b0;
                    n_count = '0;
                    n_run   = 1'b0;
                end
                default: ;
            endcase
        end else if (fire) begin
            unique case (r_in_action)
                hbcm_pkg::ACT_FRAME, hbcm_pkg::ACT_FORCE: begin
                    // a forced state only needs the monitor on; a frame needs all checks
                    if ((r_in_action == hbcm_pkg::ACT_FORCE) ? mon_on : frame_ok) begin
                        n_state = r_in_st;
                        n_err   = 1'b0;
                        n_count = r_hb_ms;
                        n_run   = 1'b1;
                    end
                end
                hbcm_pkg::ACT_TICK: begin
                    if (r_run) begin
                        n_count = count_dec;
                        if (ev_exp) begin
                            n_run = 1'b0;
                            n_err = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // -- result buffer: advance on pop, append new results behind what remains --------------
    always_comb begin
        n_ob[0] = r_ob[0];
        n_ob[1] = r_ob[1];
        if (pop) begin
            n_ob[0] = r_ob[1];
        end
        if (fire && (nres != 2'd0)) begin
            n_ob[cnt_after_pop[0]] = res0;
        end
        if (fire && (nres == 2'd2)) begin
            n_ob[1] = res1;
        end
        n_ob_cnt   = cnt_after_pop + (fire ? nres : 2'd0);
        n_in_valid = in_accept || (r_in_valid && !fire);
    end

    // -- registers -------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id  <= '0;
            r_hb_ms    <= '0;
            r_state    <= '0;
            r_err      <= 1'b0;
            r_count    <= '0;
            r_run      <= 1'b0;
            r_in_valid <= 1'b0;
            r_ob_cnt   <= 2'd0;
        end else begin
            r_node_id  <= n_node_id;
            r_hb_ms    <= n_hb_ms;
            r_state    <= n_state;
            r_err      <= n_err;
            r_count    <= n_count;
            r_run      <= n_run;
            r_in_valid <= n_in_valid;
            r_ob_cnt   <= n_ob_cnt;
        end
    end

    // payload: hold unless a new beat is taken
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_action <= hbcm_pkg::t_action'(i_s_axis_tuser);
            r_in_can_id <= i_s_axis_tdata[hbcm_pkg::CAN_ID_W-1:0];
            r_in_len    <= i_s_axis_tdata[LEN_LO +: hbcm_pkg::LEN_W];
            r_in_st     <= i_s_axis_tdata[ST_LO +: hbcm_pkg::STATE_W];
        end
        r_ob[0] <= n_ob[0];
        r_ob[1] <= n_ob[1];
    end

endmodule

[rtl/core/hbcm_checker.sv]
// Port-level checker for the heartbeat consumer monitor, bound to the top level.
// Depends on hbcm_pkg and heartbeat_consumer_monitor_unit_assert.svh.
`include "heartbeat_consumer_monitor_unit_assert.svh"

module hbcm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [hbcm_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,  // node, node_state, pad
    input logic [1:0]                          o_m_axis_tuser,  // event_kind
    input logic                                o_m_axis_tlast
);

    // a stalled result beat holds
    `HBCM_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))

    // only a state change carries a state, and that state has its toggle bit clear
    `HBCM_ASSERT_NOW(a_state_zero, o_m_axis_tvalid && (o_m_axis_tuser != hbcm_pkg::EV_CHANGED), o_m_axis_tdata[14:7] == 8'd0)
    `HBCM_ASSERT_NOW(a_toggle_clear, o_m_axis_tvalid && (o_m_axis_tuser == hbcm_pkg::EV_CHANGED), !o_m_axis_tdata[14])

    // a resolved event that is not last is followed at once by its state change
    `HBCM_ASSERT_NEXT(a_pair, o_m_axis_tvalid && i_m_axis_tready && (o_m_axis_tuser == hbcm_pkg::EV_RESOLVED) && !o_m_axis_tlast, o_m_axis_tvalid && (o_m_axis_tuser == hbcm_pkg::EV_CHANGED) && o_m_axis_tlast)

endmodule

bind heartbeat_consumer_monitor_unit hbcm_checker u_hbcm_checker (.*);
